@@ design/slp_pkg.sv @@
`timescale 1ns / 1ps
package slp_pkg;
  localparam int LINE_DEPTH = 128;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int ADDR_MAX_CHARS = 39;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic clr;        // reset scan state
    logic rd;         // issue store read at scan pointer
    logic scan;       // evaluate returned byte
    logic emit_rd;    // read address char
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic emit_done;
  } sts_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
endpackage

@@ design/status_line_parser_core.sv @@
`timescale 1ns / 1ps
// data bytes are stored as they are accepted; a line end on a non-empty line starts
// a scan of the N stored bytes, one store read per byte, then the report and one
// read per address character; input is held off until the last result is taken
// reset (rst_ni low, asynchronous) empties the line and returns to idle
module status_line_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic       last_o,
  output logic       time_found_o,
  output logic [6:0] hours_o,
  output logic [6:0] minutes_o,
  output logic       ip_marker_found_o,
  output logic [5:0] ip_length_o,
  output logic       alarm_event_o,
  output logic [1:0] alarm_slot_o,
  output logic       status_updated_o,
  output logic [7:0] ip_char_o
);
  import slp_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic wr, empty, tf, ipf, ev, elast;
  logic [6:0] hh, mm;
  logic [5:0] iplen;
  logic [1:0] slot;
  logic [7:0] ch;

  slp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i,
    .line_empty_i(empty), .sts_i(sts), .ip_length_zero_i(iplen == '0),
    .ctl_o(ctl), .wr_o(wr), .out_valid_o, .out_kind_o(kind_o), .out_ready_i
  );

  slp_datapath u_dp (
    .clk_i, .rst_ni, .wr_i(wr), .wdata_i(rx_byte_i), .ctl_i(ctl), .sts_o(sts),
    .line_empty_o(empty), .time_found_o(tf), .hours_o(hh), .minutes_o(mm),
    .ip_found_o(ipf), .ip_length_o(iplen), .alarm_event_o(ev), .alarm_slot_o(slot),
    .ip_char_o(ch), .emit_last_o(elast)
  );

  // result fields, unused ones zero
  assign last_o = kind_o ? elast : (iplen == '0);
  assign time_found_o = !kind_o && tf;
  assign hours_o = (!kind_o && tf) ? hh : '0;
  assign minutes_o = (!kind_o && tf) ? mm : '0;
  assign ip_marker_found_o = !kind_o && ipf;
  assign ip_length_o = kind_o ? '0 : iplen;
  assign alarm_event_o = !kind_o && ev;
  assign alarm_slot_o = (!kind_o && ev) ? slot : '0;
  assign status_updated_o = !kind_o && (tf || iplen != '0);
  assign ip_char_o = kind_o ? ch : '0;
endmodule

@@ design/slp_ram.sv @@
`timescale 1ns / 1ps
module slp_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ design/slp_datapath.sv @@
`timescale 1ns / 1ps
module slp_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [7:0]        wdata_i,
  input  slp_pkg::ctl_t     ctl_i,
  output slp_pkg::sts_t     sts_o,
  output logic              line_empty_o,
  output logic              time_found_o,
  output logic [6:0]        hours_o,
  output logic [6:0]        minutes_o,
  output logic              ip_found_o,
  output logic [5:0]        ip_length_o,
  output logic              alarm_event_o,
  output logic [1:0]        alarm_slot_o,
  output logic [7:0]        ip_char_o,
  output logic              emit_last_o
);
  import slp_pkg::*;

  logic [AW-1:0] len_q, len_d;
  logic [AW:0]   ptr_q;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [AW-1:0] eptr_q;
  logic [5:0]    ecnt_q;

  // shift window of the last ten bytes, w_q[0] newest
  logic [7:0] w_q [10];
  logic [3:0] wn_q;           // number of valid bytes in window, saturating
  logic        tm_hit_q, tm_done_q, ip_hit_q, ip_stop_q, ev_q, ring_hit_q, slot_done_q;
  logic [3:0]  tm_cnt_q;
  logic [7:0]  d0_q, d1_q, d3_q;
  logic [AW-1:0] ip_start_q;

  slp_ram #(.Width(8), .Depth(LINE_DEPTH)) u_ram (
    .clk_i, .we_i(wr_i && (len_q != AW'(LINE_DEPTH-1))), .waddr_i(len_q), .wdata_i,
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // while an address char waits, keep reading the same entry
  assign raddr = ctl_i.emit_rd ? eptr_q :
                 (ecnt_q != '0) ? eptr_q - 1'b1 : ptr_q[AW-1:0];
  assign line_empty_o = len_q == '0;
  assign sts_o.scan_done = ptr_q >= {1'b0, len_q};
  assign sts_o.emit_done = ecnt_q >= ip_length_o;
  assign ip_char_o = rdata;
  assign emit_last_o = ecnt_q == ip_length_o;

  // line length
  always_comb begin
    len_d = len_q;
    if (wr_i) len_d = (len_q == AW'(LINE_DEPTH-1)) ? '0 : len_q + 1'b1;
    if (ctl_i.clr && !wr_i && sts_o.emit_done && ctl_i.emit_rd) len_d = '0;
  end

  logic m_time, m_ip, m_ev, m_ring;
  always_comb begin
    m_time = wn_q >= 4'd5 && w_q[4] == "T" && w_q[3] == "I" && w_q[2] == "M" &&
             w_q[1] == "E" && w_q[0] == CH_COLON;
    m_ip   = wn_q >= 4'd3 && w_q[2] == "I" && w_q[1] == "P" && w_q[0] == CH_COLON;
    m_ring = wn_q >= 4'd4 && w_q[3] == "R" && w_q[2] == "I" && w_q[1] == "N" &&
             w_q[0] == "G";
    m_ev   = wn_q >= 4'd10 && w_q[9] == "E" && w_q[8] == "V" && w_q[7] == "E" &&
             w_q[6] == "N" && w_q[5] == "T" && w_q[4] == CH_COLON && m_ring;
  end

  // scan state, one byte per read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; ptr_q <= '0; eptr_q <= '0; ecnt_q <= '0; wn_q <= '0;
      tm_hit_q <= 1'b0; tm_done_q <= 1'b0; ip_hit_q <= 1'b0; ip_stop_q <= 1'b0;
      ev_q <= 1'b0; ring_hit_q <= 1'b0; slot_done_q <= 1'b0; tm_cnt_q <= '0;
      time_found_o <= 1'b0; ip_length_o <= '0; alarm_slot_o <= '0;
      ip_start_q <= '0;
    end else begin
      len_q <= len_d;
      if (ctl_i.clr) begin
        ptr_q <= '0; wn_q <= '0; tm_hit_q <= 1'b0; tm_done_q <= 1'b0;
        ip_hit_q <= 1'b0; ip_stop_q <= 1'b0; ev_q <= 1'b0; ring_hit_q <= 1'b0;
        slot_done_q <= 1'b0; tm_cnt_q <= '0; time_found_o <= 1'b0;
        ip_length_o <= '0; alarm_slot_o <= '0; ecnt_q <= '0;
      end
      if (ctl_i.rd) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (ctl_i.scan) begin
        // time field collects five bytes after marker
        if (tm_hit_q && !tm_done_q) begin
          tm_cnt_q <= tm_cnt_q + 1'b1;
          unique case (tm_cnt_q)
            4'd0: d0_q <= rdata;
            4'd1: d1_q <= rdata;
            4'd3: d3_q <= rdata;
            4'd4: begin
              tm_done_q <= 1'b1;
              time_found_o <= is_dig(d0_q) && is_dig(d1_q) && w_q[1] == CH_COLON &&
                              is_dig(d3_q) && is_dig(rdata);
              hours_o <= 7'((d0_q - 8'h30) * 4'd10 + (d1_q - 8'h30));
              minutes_o <= 7'((d3_q - 8'h30) * 4'd10 + (rdata - 8'h30));
            end
            default: ;
          endcase
        end
        if (ip_hit_q && !ip_stop_q) begin
          if (rdata == CH_COMMA || ip_length_o == 6'(ADDR_MAX_CHARS)) ip_stop_q <= 1'b1;
          else ip_length_o <= ip_length_o + 1'b1;
        end
        if (ring_hit_q && !slot_done_q) begin
          slot_done_q <= 1'b1;
          if (rdata >= "1" && rdata <= "3") alarm_slot_o <= rdata[1:0];
        end
        for (int i = 9; i > 0; i--) w_q[i] <= w_q[i-1];
        w_q[0] <= rdata;
        if (wn_q != 4'd10) wn_q <= wn_q + 1'b1;
      end else if (ctl_i.rd && !ctl_i.clr && ptr_q != '0) begin
        // markers checked on window after previous byte landed
        if (m_time && !tm_hit_q) tm_hit_q <= 1'b1;
        if (m_ip && !ip_hit_q) begin
          ip_hit_q <= 1'b1;
          ip_start_q <= ptr_q[AW-1:0];
        end
        if (m_ring && !ring_hit_q) ring_hit_q <= 1'b1;
        if (m_ev) ev_q <= 1'b1;
      end
      // address pointer follows the start until the first char is read
      if (ctl_i.emit_rd) begin
        eptr_q <= eptr_q + 1'b1;
        ecnt_q <= ecnt_q + 1'b1;
      end else if (ecnt_q == '0) begin
        eptr_q <= ip_start_q;
      end
    end
  end

  // final marker check at end of line
  logic ev_fin, ip_fin;
  assign ev_fin = ev_q || (sts_o.scan_done && m_ev);
  assign ip_fin = ip_hit_q || (sts_o.scan_done && m_ip);
  assign alarm_event_o = ev_fin;
  assign ip_found_o = ip_fin;
endmodule

@@ design/slp_ctrl.sv @@
`timescale 1ns / 1ps
module slp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          line_empty_i,
  input  slp_pkg::sts_t sts_i,
  input  logic          ip_length_zero_i,
  output slp_pkg::ctl_t ctl_o,
  output logic          wr_o,
  output logic          out_valid_o,
  output logic          out_kind_o,
  input  logic          out_ready_i
);
  import slp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EV = 3'd2, S_FIN = 3'd3,
                         S_REP = 3'd4, S_ERD = 3'd5, S_CHR = 3'd6;
  logic [2:0] st_q, st_d;
  logic eol, acc;

  assign in_ready_o = st_q == S_IDLE;
  assign acc = in_valid_i && in_ready_o;
  assign eol = rx_byte_i == CH_LF || rx_byte_i == CH_CR;
  assign wr_o = acc && !eol;
  assign out_valid_o = st_q == S_REP || st_q == S_CHR;
  assign out_kind_o = st_q == S_CHR;

  // sequencer
  always_comb begin
    st_d = st_q;
    ctl_o = '0;
    unique case (st_q)
      S_IDLE: if (acc && eol && !line_empty_i) begin
        ctl_o.clr = 1'b1; st_d = S_RD;
      end
      S_RD: if (sts_i.scan_done) st_d = S_FIN;
            else begin ctl_o.rd = 1'b1; st_d = S_EV; end
      S_EV: begin ctl_o.scan = 1'b1; st_d = S_RD; end
      S_FIN: st_d = S_REP;
      S_REP: if (out_ready_i) begin
        if (ip_length_zero_i) begin st_d = S_IDLE; ctl_o.emit_rd = 1'b1; ctl_o.clr = 1'b1; end
        else begin st_d = S_ERD; end
      end
      S_ERD: begin ctl_o.emit_rd = 1'b1; st_d = S_CHR; end
      S_CHR: if (out_ready_i) begin
        if (sts_i.emit_done) begin
          st_d = S_IDLE; ctl_o.emit_rd = 1'b1; ctl_o.clr = 1'b1;
        end else st_d = S_ERD;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end
endmodule

@@ design/slp_checker.sv @@
`timescale 1ns / 1ps
module slp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic kind_o,
  input logic [7:0] ip_char_o
);
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("result dropped");
  a_rep_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> ip_char_o == 8'd0) else $error("report carries char");
endmodule

bind status_line_parser_core slp_checker u_chk (.*);

@@ dv/status_line_parser_core_tb.sv @@
`timescale 1ns / 1ps
module status_line_parser_core_tb;
  import slp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic       last;
    logic       time_found;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic       ip_marker_found;
    logic [5:0] ip_length;
    logic       alarm_event;
    logic [1:0] alarm_slot;
    logic       status_updated;
    logic [7:0] ip_char;
  } line_report_t;

  // line parser prediction and report checking
  class line_report_board;
    logic [7:0]   line_buf[LINE_DEPTH];
    int unsigned  line_len;
    line_report_t pending_q[$];
    int unsigned  mismatch_cnt;

    function automatic int find_mark(string pat);
      int i;
      int j;
      int ok;
      if (pat.len() > line_len) return -1;
      for (i = 0; i + pat.len() <= line_len; i++) begin
        ok = 1;
        for (j = 0; j < pat.len(); j++)
          if (line_buf[i + j] != pat[j]) ok = 0;
        if (ok) return i;
      end
      return -1;
    endfunction

    function automatic bit digit_at(int pos);
      return line_buf[pos] >= "0" && line_buf[pos] <= "9";
    endfunction

    // note one accepted byte, predict the reports of a finished line
    function void note_byte(logic [7:0] b);
      line_report_t r;
      int p;
      int q;
      int ip_start;
      int ip_len;
      if (b != CH_LF && b != CH_CR) begin
        if (line_len >= LINE_DEPTH - 1) line_len = 0;
        else begin
          line_buf[line_len] = b;
          line_len++;
        end
        return;
      end
      if (line_len == 0) return;
      r = '0;
      p = find_mark("TIME:");
      if (p >= 0) begin
        q = p + 5;
        if (q + 5 <= line_len && digit_at(q) && digit_at(q + 1) &&
            line_buf[q + 2] == CH_COLON && digit_at(q + 3) && digit_at(q + 4)) begin
          r.time_found = 1'b1;
          r.hours = 7'((line_buf[q] - 8'h30) * 10 + (line_buf[q + 1] - 8'h30));
          r.minutes = 7'((line_buf[q + 3] - 8'h30) * 10 + (line_buf[q + 4] - 8'h30));
        end
      end
      ip_len = 0;
      ip_start = 0;
      p = find_mark("IP:");
      if (p >= 0) begin
        r.ip_marker_found = 1'b1;
        ip_start = p + 3;
        while (ip_start + ip_len < line_len && ip_len < ADDR_MAX_CHARS &&
               line_buf[ip_start + ip_len] != CH_COMMA)
          ip_len++;
      end
      if (find_mark("EVENT:RING") >= 0) begin
        r.alarm_event = 1'b1;
        p = find_mark("RING");
        q = p + 4;
        if (q < line_len && line_buf[q] >= "1" && line_buf[q] <= "3")
          r.alarm_slot = 2'(line_buf[q] - 8'h30);
      end
      r.ip_length = 6'(ip_len);
      r.last = (ip_len == 0);
      r.status_updated = r.time_found || ip_len > 0;
      pending_q.push_back(r);
      for (int k = 0; k < ip_len; k++) begin
        r = '0;
        r.kind = 1'b1;
        r.last = (k + 1 == ip_len);
        r.ip_char = line_buf[ip_start + k];
        pending_q.push_back(r);
      end
      line_len = 0;
    endfunction

    function void check_report(line_report_t act);
      line_report_t exp_r;
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", act);
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r !== act) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch: expected %p actual %p", exp_r, act);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  line_report_t act_rep;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  line_report_board board;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  status_line_parser_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i,
    .out_valid_o, .out_ready_i,
    .kind_o(act_rep.kind), .last_o(act_rep.last),
    .time_found_o(act_rep.time_found), .hours_o(act_rep.hours),
    .minutes_o(act_rep.minutes), .ip_marker_found_o(act_rep.ip_marker_found),
    .ip_length_o(act_rep.ip_length), .alarm_event_o(act_rep.alarm_event),
    .alarm_slot_o(act_rep.alarm_slot), .status_updated_o(act_rep.status_updated),
    .ip_char_o(act_rep.ip_char)
  );

  // receiver: random stall, check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_report(act_rep);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // drive one byte, with random idle ahead of it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic end_line();
    send_byte($urandom_range(1) ? CH_LF : CH_CR);
  endtask

  function automatic string digit_str(int n);
    string s;
    for (int i = 0; i < n; i++) s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string noise_str(int n);
    string s;
    byte c;
    for (int i = 0; i < n; i++) begin
      c = byte'($urandom_range(32, 126));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // status line with random content, sometimes malformed
  task automatic send_random_line();
    int pick;
    pick = $urandom_range(7);
    if (pick[0]) send_text({"TIME:", digit_str(2),
                            string'(byte'($urandom_range(4) ? ":" : "x")),
                            digit_str(2), " "});
    if (pick[1]) begin
      send_text({"IP:", noise_str($urandom_range(1, 8))});
      if ($urandom_range(1)) send_byte(CH_COMMA);
    end
    if (pick[2]) send_text({" EVENT:RING", string'(byte'($urandom_range(48, 53)))});
    if ($urandom_range(3) == 0) send_text(noise_str($urandom_range(0, 6)));
    end_line();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    send_idle_pct = 20;
    recv_idle_pct = 49;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines: markers, edges, overflow, zero and high bytes
    end_line();
    send_text("TIME:00:00 IP:1.2.3.4,x EVENT:RING3");
    end_line();
    send_text("TIME:99:59");
    end_line();
    send_text("TIME:1");
    end_line();
    send_text("IP:");
    end_line();
    send_text("EVENT:RING");
    end_line();
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("IP:");
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(CH_CR);
    send_text({"IP:", noise_str(42)});
    send_byte(CH_LF);
    for (int i = 0; i < 130; i++) send_byte(8'("A" + (i % 20)));
    send_text("TIME:12:34");
    end_line();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 20 : 0;
      for (int n = 0; n < 3; n++) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
        else send_random_line();
      end
    end
    wait_drained();

    if (board.mismatch_cnt == 0 && board.pending_q.size() == 0)
      $display("PASS status_line_parser_core");
    else
      $display("FAIL status_line_parser_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL status_line_parser_core");
    $finish;
  end
endmodule

@@ filelist.f @@
design/slp_pkg.sv
design/slp_ram.sv
design/slp_datapath.sv
design/slp_ctrl.sv
design/status_line_parser_core.sv
design/slp_checker.sv
dv/status_line_parser_core_tb.sv
